// ===== rtl/lwf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lwf_pkg
// Shared types, widths and constants of the lidar wall following controller.
// ----------------------------------------------------------------------------
package lwf_pkg;

   // Field widths of the channels.
   localparam int RANGE_W     = 16;
   localparam int SPEED_W     = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Default scan depth of the sample counter.
   localparam int MAX_POINTS_DEF = 1024;

   // Register reset values.
   localparam logic [10:0] SCAN_POINTS_RST = 11'd1024;
   localparam logic [9:0]  PROBE_INDEX_RST = 10'd10;
   localparam logic [15:0] COS_PROBE_RST   = 16'd32736;
   localparam logic [15:0] MAX_SPEED_RST   = 16'd640;
   localparam logic [15:0] TARGET_RST      = 16'd1280;
   localparam logic [15:0] NEAR_RST        = 16'd1254;
   localparam logic [15:0] FAR_RST         = 16'd2560;

   // Arithmetic constants.
   localparam logic [15:0] RANGE_START = 16'd7680;
   localparam logic [15:0] COS_ONE     = 16'd32768;
   localparam logic [14:0] HALF_PI_Q14 = 15'd25736;
   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
   localparam logic [39:0] ONE_Q14     = 40'd16384;

   // Reciprocals floor(2^32 / q) of the sine polynomial divisors, and the divisors.
   localparam logic [31:0] POLY_RECIP [6] = '{
      32'd27531841, 32'd39045157, 32'd59652323,
      32'd102261126, 32'd214748364, 32'd715827882
   };
   localparam logic [7:0] POLY_DIV [6] = '{
      8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
   };
   localparam logic [2:0] POLY_LAST = 3'd5;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCAN_POINTS = 3'd0,
      CSR_PROBE_INDEX = 3'd1,
      CSR_COS_PROBE   = 3'd2,
      CSR_MAX_SPEED   = 3'd3,
      CSR_TARGET      = 3'd4,
      CSR_NEAR        = 3'd5,
      CSR_FAR         = 3'd6
   } csr_index_type;

   // Controller states.
   typedef enum logic [4:0] {
      S_SCAN, S_MUL_DD, S_MUL_PP, S_MUL_DP, S_MUL_DPC, S_K2, S_SQRT, S_MUL_PC,
      S_ARG_INIT, S_ARG_DIV, S_ASIN_INIT, S_BIS_TEST, S_SQ, S_X2, S_P_MUL,
      S_P_RCP, S_P_QM, S_P_FIX, S_S_MUL, S_S_CMP, S_LIN_M1, S_LIN_M2,
      S_LIN_INIT, S_LIN_DIV, S_OUT_CALC
   } state_type;

   // Datapath operations.
   typedef enum logic [4:0] {
      OP_NONE, OP_MUL_DD, OP_MUL_PP, OP_MUL_DP, OP_MUL_DPC, OP_K2, OP_SQRT,
      OP_MUL_PC, OP_ARG_INIT, OP_DIV, OP_ASIN_INIT, OP_BIS_TEST, OP_SQ, OP_X2,
      OP_P_MUL, OP_P_RCP, OP_P_QM, OP_P_FIX, OP_S_MUL, OP_S_CMP, OP_LIN_M1,
      OP_LIN_M2, OP_LIN_INIT, OP_OUT
   } op_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      op_type op;
      logic   sample_en;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_last;
      logic sqrt_last;
      logic div_last;
      logic poly_last;
      logic bis_done;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/lwf_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lwf_req_if
// Range sample channel: one item is one lidar range reading.
// ----------------------------------------------------------------------------
interface lwf_req_if;
   logic                         valid;
   logic                         ready;
   logic [lwf_pkg::RANGE_W-1:0]  range_sample;

   modport source (output valid, output range_sample, input ready);
   modport sink   (input valid, input range_sample, output ready);
endinterface
`default_nettype wire

// ===== rtl/lwf_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lwf_rsp_if
// Command channel: one item per completed scan.
// ----------------------------------------------------------------------------
interface lwf_rsp_if;
   logic                               valid;
   logic                               ready;
   logic        [lwf_pkg::SPEED_W-1:0] linear_speed;
   logic signed [lwf_pkg::SPEED_W-1:0] angular_speed;
   logic signed [lwf_pkg::SPEED_W-1:0] wall_angle;

   modport source (output valid, output linear_speed, output angular_speed,
                   output wall_angle, input ready);
   modport sink   (input valid, input linear_speed, input angular_speed,
                   input wall_angle, output ready);
endinterface
`default_nettype wire

// ===== rtl/lwf_csr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lwf_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lwf_csr_if;
   logic                             valid;
   logic                             ready;
   logic [lwf_pkg::CSR_INDEX_W-1:0]  index;
   logic [lwf_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/lwf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lwf_ctrl
// Sequencer of the scan and of the end-of-scan computation, plus the output
// valid flag.
// ----------------------------------------------------------------------------
module lwf_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire lwf_pkg::status_type status,
   output lwf_pkg::cmd_type         cmd
);

   lwf_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic out_load;

   // The output register can take a new item once the old one is gone.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == lwf_pkg::S_SCAN);
   assign rsp_valid = rsp_valid_ff;
   assign out_load  = (state_ff == lwf_pkg::S_OUT_CALC) && out_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lwf_pkg::S_SCAN: begin
            if (req_valid && status.is_last) state_in = lwf_pkg::S_MUL_DD;
         end
         lwf_pkg::S_MUL_DD:   state_in = lwf_pkg::S_MUL_PP;
         lwf_pkg::S_MUL_PP:   state_in = lwf_pkg::S_MUL_DP;
         lwf_pkg::S_MUL_DP:   state_in = lwf_pkg::S_MUL_DPC;
         lwf_pkg::S_MUL_DPC:  state_in = lwf_pkg::S_K2;
         lwf_pkg::S_K2:       state_in = lwf_pkg::S_SQRT;
         lwf_pkg::S_SQRT: begin
            if (status.sqrt_last) state_in = lwf_pkg::S_MUL_PC;
         end
         lwf_pkg::S_MUL_PC:   state_in = lwf_pkg::S_ARG_INIT;
         lwf_pkg::S_ARG_INIT: state_in = lwf_pkg::S_ARG_DIV;
         lwf_pkg::S_ARG_DIV: begin
            if (status.div_last) state_in = lwf_pkg::S_ASIN_INIT;
         end
         lwf_pkg::S_ASIN_INIT: state_in = lwf_pkg::S_BIS_TEST;
         lwf_pkg::S_BIS_TEST: begin
            if (status.bis_done) state_in = lwf_pkg::S_LIN_M1;
            else                 state_in = lwf_pkg::S_SQ;
         end
         lwf_pkg::S_SQ:       state_in = lwf_pkg::S_X2;
         lwf_pkg::S_X2:       state_in = lwf_pkg::S_P_MUL;
         lwf_pkg::S_P_MUL:    state_in = lwf_pkg::S_P_RCP;
         lwf_pkg::S_P_RCP:    state_in = lwf_pkg::S_P_QM;
         lwf_pkg::S_P_QM:     state_in = lwf_pkg::S_P_FIX;
         lwf_pkg::S_P_FIX: begin
            if (status.poly_last) state_in = lwf_pkg::S_S_MUL;
            else                  state_in = lwf_pkg::S_P_MUL;
         end
         lwf_pkg::S_S_MUL:    state_in = lwf_pkg::S_S_CMP;
         lwf_pkg::S_S_CMP:    state_in = lwf_pkg::S_BIS_TEST;
         lwf_pkg::S_LIN_M1:   state_in = lwf_pkg::S_LIN_M2;
         lwf_pkg::S_LIN_M2:   state_in = lwf_pkg::S_LIN_INIT;
         lwf_pkg::S_LIN_INIT: state_in = lwf_pkg::S_LIN_DIV;
         lwf_pkg::S_LIN_DIV: begin
            if (status.div_last) state_in = lwf_pkg::S_OUT_CALC;
         end
         lwf_pkg::S_OUT_CALC: begin
            if (out_free) state_in = lwf_pkg::S_SCAN;
         end
         default: state_in = lwf_pkg::S_SCAN;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd.sample_en = req_ready && req_valid;
      cmd.op        = lwf_pkg::OP_NONE;
      unique case (state_ff)
         lwf_pkg::S_SCAN:      cmd.op = lwf_pkg::OP_NONE;
         lwf_pkg::S_MUL_DD:    cmd.op = lwf_pkg::OP_MUL_DD;
         lwf_pkg::S_MUL_PP:    cmd.op = lwf_pkg::OP_MUL_PP;
         lwf_pkg::S_MUL_DP:    cmd.op = lwf_pkg::OP_MUL_DP;
         lwf_pkg::S_MUL_DPC:   cmd.op = lwf_pkg::OP_MUL_DPC;
         lwf_pkg::S_K2:        cmd.op = lwf_pkg::OP_K2;
         lwf_pkg::S_SQRT:      cmd.op = lwf_pkg::OP_SQRT;
         lwf_pkg::S_MUL_PC:    cmd.op = lwf_pkg::OP_MUL_PC;
         lwf_pkg::S_ARG_INIT:  cmd.op = lwf_pkg::OP_ARG_INIT;
         lwf_pkg::S_ARG_DIV:   cmd.op = lwf_pkg::OP_DIV;
         lwf_pkg::S_ASIN_INIT: cmd.op = lwf_pkg::OP_ASIN_INIT;
         lwf_pkg::S_BIS_TEST:  cmd.op = lwf_pkg::OP_BIS_TEST;
         lwf_pkg::S_SQ:        cmd.op = lwf_pkg::OP_SQ;
         lwf_pkg::S_X2:        cmd.op = lwf_pkg::OP_X2;
         lwf_pkg::S_P_MUL:     cmd.op = lwf_pkg::OP_P_MUL;
         lwf_pkg::S_P_RCP:     cmd.op = lwf_pkg::OP_P_RCP;
         lwf_pkg::S_P_QM:      cmd.op = lwf_pkg::OP_P_QM;
         lwf_pkg::S_P_FIX:     cmd.op = lwf_pkg::OP_P_FIX;
         lwf_pkg::S_S_MUL:     cmd.op = lwf_pkg::OP_S_MUL;
         lwf_pkg::S_S_CMP:     cmd.op = lwf_pkg::OP_S_CMP;
         lwf_pkg::S_LIN_M1:    cmd.op = lwf_pkg::OP_LIN_M1;
         lwf_pkg::S_LIN_M2:    cmd.op = lwf_pkg::OP_LIN_M2;
         lwf_pkg::S_LIN_INIT:  cmd.op = lwf_pkg::OP_LIN_INIT;
         lwf_pkg::S_LIN_DIV:   cmd.op = lwf_pkg::OP_DIV;
         lwf_pkg::S_OUT_CALC:  cmd.op = out_load ? lwf_pkg::OP_OUT : lwf_pkg::OP_NONE;
         default:              cmd.op = lwf_pkg::OP_NONE;
      endcase
   end

   // Output valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lwf_pkg::S_SCAN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/lwf_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lwf_dpath
// Configuration registers, per-sample scan capture and the end-of-scan
// arithmetic: a shared registered multiplier, a bit-serial square root and
// divider, and the arcsine bisection over the sine polynomial.
// ----------------------------------------------------------------------------
module lwf_dpath #(
   parameter int MAX_POINTS = lwf_pkg::MAX_POINTS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire lwf_pkg::cmd_type                   cmd,
   output lwf_pkg::status_type                     status,
   input  wire logic [lwf_pkg::RANGE_W-1:0]        range_sample,
   input  wire logic                               csr_we,
   input  wire logic [lwf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [lwf_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic        [lwf_pkg::SPEED_W-1:0]      linear_speed,
   output logic signed [lwf_pkg::SPEED_W-1:0]      angular_speed,
   output logic signed [lwf_pkg::SPEED_W-1:0]      wall_angle
);

   localparam int CNT_W = $clog2(MAX_POINTS);
   localparam int LW    = (CNT_W + 1 > 11) ? CNT_W + 1 : 11;

   // Configuration registers.
   logic [10:0] scan_points_ff;
   logic [9:0]  probe_index_ff;
   logic [15:0] cos_ff, max_speed_ff, target_ff, near_ff, far_ff;

   // Scan state.
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0] minr_ff, minr_in, first_ff, first_in;
   logic [15:0] probe_ff, probe_in, front_ff, front_in;
   logic [15:0] min_base;
   logic [LW-1:0] sp_ext, len, last_idx, front_idx, cnt_ext, probe_ext;

   // Arithmetic registers.
   logic [63:0] mul_ff, mul_in;
   logic [31:0] mul_a, mul_b;
   logic [32:0] acc_ff, acc_in;
   logic [48:0] rad_ff, rad_in;
   logic [49:0] root_ff, root_in;
   logic [48:0] bit_ff, bit_in;
   logic        neg_ff, neg_in;
   logic        pos_ff, pos_in;
   logic [39:0] dvd_ff, dvd_in;
   logic [24:0] rem_ff, rem_in;
   logic [24:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [14:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [29:0] tgt_ff, tgt_in;
   logic [31:0] x2_ff, x2_in, y_ff, y_in;
   logic [30:0] t_ff, t_in;
   logic [2:0]  idx_ff, idx_in;
   logic signed [15:0] ang_ff, ang_in;
   logic [15:0] lin_out_ff, lin_out_in;
   logic signed [15:0] angs_out_ff, angs_out_in, wall_out_ff, wall_out_in;

   // Combinational helpers.
   logic [15:0] c_sat;
   logic [49:0] sq_sum;
   logic [25:0] trial;
   logic        ge;
   logic [32:0] num, num_abs;
   logic [15:0] lo_hi_sum;
   logic [31:0] rfix, qfix;
   logic [16:0] fn, fr, fn_abs, fr_abs;
   logic signed [16:0] diff;
   logic signed [25:0] wv, wq;
   logic [15:0] far_eff;

   assign c_sat   = (cos_ff > lwf_pkg::COS_ONE) ? lwf_pkg::COS_ONE : cos_ff;
   assign far_eff = (far_ff == 16'd0) ? 16'd1 : far_ff;

   // Effective scan length and indexes.
   always_comb begin
      sp_ext = LW'(scan_points_ff);
      if (sp_ext > LW'(MAX_POINTS))  len = LW'(MAX_POINTS);
      else if (sp_ext == '0)         len = LW'(1);
      else                           len = sp_ext;
      last_idx  = len - LW'(1);
      front_idx = last_idx >> 1;
      cnt_ext   = LW'(count_ff);
      probe_ext = LW'(probe_index_ff);
   end

   // Status to the controller.
   assign status.is_last   = cnt_ext >= last_idx;
   assign status.sqrt_last = bit_ff[0];
   assign status.div_last  = (cnt_ff == 6'd0);
   assign status.poly_last = (idx_ff == lwf_pkg::POLY_LAST);
   assign status.bis_done  = (lo_ff >= hi_ff);

   // Capture of the scan samples.
   always_comb begin
      count_in = count_ff;
      minr_in  = minr_ff;
      first_in = first_ff;
      probe_in = probe_ff;
      front_in = front_ff;
      min_base = (count_ff == '0) ? lwf_pkg::RANGE_START : minr_ff;
      if (cmd.sample_en) begin
         if (count_ff == '0) begin
            first_in = range_sample;
            probe_in = '0;
            front_in = '0;
         end
         if (cnt_ext == probe_ext) probe_in = range_sample;
         if (cnt_ext == front_idx) front_in = range_sample;
         minr_in = min_base;
         if (cnt_ext <= front_idx && range_sample < min_base) minr_in = range_sample;
         count_in = status.is_last ? '0 : count_ff + CNT_W'(1);
      end
   end

   // Operand selection of the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         lwf_pkg::OP_MUL_DD:  begin mul_a = 32'(first_ff); mul_b = 32'(first_ff); end
         lwf_pkg::OP_MUL_PP:  begin mul_a = 32'(probe_ff); mul_b = 32'(probe_ff); end
         lwf_pkg::OP_MUL_DP:  begin mul_a = 32'(first_ff); mul_b = 32'(probe_ff); end
         lwf_pkg::OP_MUL_DPC: begin mul_a = mul_ff[31:0];  mul_b = 32'(c_sat); end
         lwf_pkg::OP_MUL_PC:  begin mul_a = 32'(probe_ff); mul_b = 32'(c_sat); end
         lwf_pkg::OP_SQ:      begin mul_a = 32'(mid_ff);   mul_b = 32'(mid_ff); end
         lwf_pkg::OP_P_MUL:   begin mul_a = x2_ff;         mul_b = 32'(t_ff); end
         lwf_pkg::OP_P_RCP: begin
            mul_a = mul_ff[61:30];
            mul_b = lwf_pkg::POLY_RECIP[idx_ff];
         end
         lwf_pkg::OP_P_QM: begin
            mul_a = mul_ff[63:32];
            mul_b = 32'(lwf_pkg::POLY_DIV[idx_ff]);
         end
         lwf_pkg::OP_S_MUL:   begin mul_a = 32'(mid_ff);   mul_b = 32'(t_ff); end
         lwf_pkg::OP_LIN_M1:  begin mul_a = 32'(fn_abs);   mul_b = 32'(fr_abs); end
         lwf_pkg::OP_LIN_M2:  begin mul_a = mul_ff[31:0];  mul_b = 32'(max_speed_ff); end
         default: ;
      endcase
      mul_in = 64'(mul_a) * 64'(mul_b);
   end

   // Shared arithmetic helpers.
   always_comb begin
      sq_sum    = root_ff + {1'b0, bit_ff};
      trial     = {rem_ff, dvd_ff[39]};
      ge        = trial >= {1'b0, dsr_ff};
      num       = {1'b0, mul_ff[31:0]} - {2'b00, first_ff, 15'd0};
      num_abs   = num[32] ? (33'd0 - num) : num;
      lo_hi_sum = 16'(lo_ff) + 16'(hi_ff) + 16'd1;
      // The quotient estimate sits in the low word of dvd_ff; it is at most
      // one short, so a single compare of the remainder settles it.
      rfix      = y_ff - mul_ff[31:0];
      qfix      = (rfix >= 32'(lwf_pkg::POLY_DIV[idx_ff])) ? dvd_ff[31:0] + 32'd1
                                                           : dvd_ff[31:0];
      fn        = {1'b0, far_ff} - {1'b0, near_ff};
      fr        = {1'b0, front_ff} - {1'b0, near_ff};
      fn_abs    = fn[16] ? (17'd0 - fn) : fn;
      fr_abs    = fr[16] ? (17'd0 - fr) : fr;
      diff      = $signed({1'b0, target_ff}) - $signed({1'b0, minr_ff});
      wv        = (26'(diff) <<< 7) + (26'(diff) <<< 6) - (26'(ang_ff) <<< 1);
      wq        = (wv < 0) ? ((wv + 26'sd63) >>> 6) : (wv >>> 6);
   end

   // End-of-scan operations.
   always_comb begin
      acc_in      = acc_ff;
      rad_in      = rad_ff;
      root_in     = root_ff;
      bit_in      = bit_ff;
      neg_in      = neg_ff;
      pos_in      = pos_ff;
      dvd_in      = dvd_ff;
      rem_in      = rem_ff;
      dsr_in      = dsr_ff;
      cnt_in      = cnt_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      tgt_in      = tgt_ff;
      x2_in       = x2_ff;
      y_in        = y_ff;
      t_in        = t_ff;
      idx_in      = idx_ff;
      ang_in      = ang_ff;
      lin_out_in  = lin_out_ff;
      angs_out_in = angs_out_ff;
      wall_out_in = wall_out_ff;
      case (cmd.op)
         // Sum of squares of the first and probe ranges.
         lwf_pkg::OP_MUL_PP: acc_in = 33'(mul_ff[31:0]);
         lwf_pkg::OP_MUL_DP: acc_in = acc_ff + 33'(mul_ff[31:0]);
         // Squared chord, scaled by 2^16, and the root setup.
         lwf_pkg::OP_K2: begin
            rad_in  = {acc_ff, 16'd0} - {mul_ff[46:0], 2'b00};
            root_in = '0;
            bit_in  = 49'd1 << 48;
         end
         // One root bit per cycle.
         lwf_pkg::OP_SQRT: begin
            if ({1'b0, rad_ff} >= sq_sum) begin
               rad_in  = rad_ff - sq_sum[48:0];
               root_in = (root_ff >> 1) + {1'b0, bit_ff};
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         // Arcsine argument: divide the scaled numerator by the chord.
         lwf_pkg::OP_ARG_INIT: begin
            neg_in = num[32];
            dvd_in = {1'b0, num_abs[31:0], 7'd0};
            dsr_in = root_ff[24:0];
            rem_in = '0;
            cnt_in = 6'd39;
         end
         // One quotient bit per cycle.
         lwf_pkg::OP_DIV: begin
            rem_in = ge ? 25'(trial - {1'b0, dsr_ff}) : trial[24:0];
            dvd_in = {dvd_ff[38:0], ge};
            cnt_in = cnt_ff - 6'd1;
         end
         // Bisection bounds; a zero chord or a full argument settle at once.
         lwf_pkg::OP_ASIN_INIT: begin
            tgt_in = {dvd_ff[13:0], 16'd0};
            if (root_ff == '0) begin
               lo_in = '0;
               hi_in = '0;
            end else if (dvd_ff >= lwf_pkg::ONE_Q14) begin
               lo_in = lwf_pkg::HALF_PI_Q14;
               hi_in = lwf_pkg::HALF_PI_Q14;
            end else begin
               lo_in = '0;
               hi_in = lwf_pkg::HALF_PI_Q14;
            end
         end
         lwf_pkg::OP_BIS_TEST: mid_in = lo_hi_sum[15:1];
         lwf_pkg::OP_X2: begin
            x2_in  = {mul_ff[29:0], 2'b00};
            t_in   = lwf_pkg::ONE_Q30;
            idx_in = '0;
         end
         lwf_pkg::OP_P_RCP: y_in = mul_ff[61:30];
         // Quotient estimate from the reciprocal; kept until the fix-up.
         lwf_pkg::OP_P_QM: dvd_in = {8'd0, mul_ff[63:32]};
         lwf_pkg::OP_P_FIX: begin
            t_in   = lwf_pkg::ONE_Q30 - qfix[30:0];
            idx_in = idx_ff + 3'd1;
         end
         lwf_pkg::OP_S_CMP: begin
            if ({1'b0, mul_ff[46:14]} <= {4'd0, tgt_ff}) lo_in = mid_ff;
            else                                         hi_in = mid_ff - 15'd1;
         end
         // Signed angle and the speed ramp product.
         lwf_pkg::OP_LIN_M1: begin
            ang_in = neg_ff ? -$signed({1'b0, lo_ff}) : $signed({1'b0, lo_ff});
            pos_in = (fn[16] == fr[16]);
         end
         lwf_pkg::OP_LIN_INIT: begin
            dvd_in = mul_ff[47:8];
            dsr_in = 25'(far_eff);
            rem_in = '0;
            cnt_in = 6'd39;
         end
         // Result registers.
         lwf_pkg::OP_OUT: begin
            if (!pos_ff)                            lin_out_in = '0;
            else if (dvd_ff > 40'(max_speed_ff))    lin_out_in = max_speed_ff;
            else                                    lin_out_in = dvd_ff[15:0];
            if (wq > 26'sd32767)       angs_out_in = 16'sh7FFF;
            else if (wq < -26'sd32768) angs_out_in = -16'sh8000;
            else                       angs_out_in = wq[15:0];
            wall_out_in = ang_ff;
         end
         default: ;
      endcase
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_points_ff <= lwf_pkg::SCAN_POINTS_RST;
         probe_index_ff <= lwf_pkg::PROBE_INDEX_RST;
         cos_ff         <= lwf_pkg::COS_PROBE_RST;
         max_speed_ff   <= lwf_pkg::MAX_SPEED_RST;
         target_ff      <= lwf_pkg::TARGET_RST;
         near_ff        <= lwf_pkg::NEAR_RST;
         far_ff         <= lwf_pkg::FAR_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            lwf_pkg::CSR_SCAN_POINTS: scan_points_ff <= csr_data[10:0];
            lwf_pkg::CSR_PROBE_INDEX: probe_index_ff <= csr_data[9:0];
            lwf_pkg::CSR_COS_PROBE:   cos_ff         <= csr_data;
            lwf_pkg::CSR_MAX_SPEED:   max_speed_ff   <= csr_data;
            lwf_pkg::CSR_TARGET:      target_ff      <= csr_data;
            lwf_pkg::CSR_NEAR:        near_ff        <= csr_data;
            lwf_pkg::CSR_FAR:         far_ff         <= csr_data;
            default: ;
         endcase
      end
   end

   // Scan state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         minr_ff  <= lwf_pkg::RANGE_START;
         first_ff <= '0;
         probe_ff <= '0;
         front_ff <= '0;
      end else begin
         count_ff <= count_in;
         minr_ff  <= minr_in;
         first_ff <= first_in;
         probe_ff <= probe_in;
         front_ff <= front_in;
      end
   end

   // Bit-serial iteration counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
         cnt_ff <= '0;
         idx_ff <= '0;
         lo_ff  <= '0;
         hi_ff  <= '0;
      end else begin
         bit_ff <= bit_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
      end
   end

   // Arithmetic payload registers.
   always_ff @(posedge clock) begin
      mul_ff      <= mul_in;
      acc_ff      <= acc_in;
      rad_ff      <= rad_in;
      root_ff     <= root_in;
      neg_ff      <= neg_in;
      pos_ff      <= pos_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      dsr_ff      <= dsr_in;
      mid_ff      <= mid_in;
      tgt_ff      <= tgt_in;
      x2_ff       <= x2_in;
      y_ff        <= y_in;
      t_ff        <= t_in;
      ang_ff      <= ang_in;
      lin_out_ff  <= lin_out_in;
      angs_out_ff <= angs_out_in;
      wall_out_ff <= wall_out_in;
   end

   assign linear_speed  = lin_out_ff;
   assign angular_speed = angs_out_ff;
   assign wall_angle    = wall_out_ff;

endmodule
`default_nettype wire

// ===== rtl/lidar_wall_following_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_wall_following_controller
// Wall following controller fed by a stream of lidar range samples.
// ----------------------------------------------------------------------------
// One range sample is taken per clock during a scan. The scan's last sample
// starts the end-of-scan computation, during which no sample is taken: the
// products, the square root and the division for the arcsine argument, up to
// 15 bisection steps that each evaluate the sine polynomial, and the speed
// ramp. The length of this computation is set by the single shared 32x32
// multiplier and the one-bit-per-cycle root and divider. The result then sits
// in an output register while the next scan's samples are already taken; a
// second result waits only if the previous one has not been taken.
// ----------------------------------------------------------------------------
module lidar_wall_following_controller #(
   parameter int MAX_POINTS = lwf_pkg::MAX_POINTS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lwf_req_if.sink    req_chan,
   lwf_rsp_if.source  rsp_chan,
   lwf_csr_if.sink    csr_chan
);

   lwf_pkg::cmd_type    cmd;
   lwf_pkg::status_type status;

   // Configuration writes are always taken.
   assign csr_chan.ready = 1'b1;

   lwf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lwf_dpath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .range_sample  (req_chan.range_sample),
      .csr_we        (csr_chan.valid),
      .csr_index     (csr_chan.index),
      .csr_data      (csr_chan.data),
      .linear_speed  (rsp_chan.linear_speed),
      .angular_speed (rsp_chan.angular_speed),
      .wall_angle    (rsp_chan.wall_angle)
   );

endmodule
`default_nettype wire
